@@ rtl/tvi_pkg.sv @@
// Shared types and constants for the tetrahedron voxel interpolator.
// Used by tvi_ctrl, tvi_datapath, tvi_checker and the top level; depends on nothing.
package tvi_pkg;

    // Field formats
    localparam int COORD_W         = 19;
    localparam int COORD_FRAC_BITS = 8;
    localparam int INDEX_BITS      = 10;
    localparam int VALUE_W         = 32;
    localparam int SLOT_W          = 2;
    localparam int NUM_VERT        = 4;

    // Internal widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DET_W   = 63;
    localparam int NUM_W   = 97;
    localparam int MA_W    = 42;
    localparam int MB_W    = 22;
    localparam int MP_W    = MA_W + MB_W;
    localparam int CHUNK_W = 21;
    localparam int QUO_W   = 33;
    localparam int MAG_W   = QUO_W + 1;

    // Sequencer counts
    localparam int NUM_TERMS  = 6;
    localparam int NUM_CHUNKS = 3;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Substitution select: vertex index, or none for the tetrahedron itself
    localparam logic [2:0] SEL_NONE = 3'd4;
    localparam logic [2:0] SEL_LAST = 3'd3;

    // Cofactor terms of the 3x3 determinant: x from row a (term/2),
    // y from row b, z from row c, and the sign of the term
    localparam logic [1:0] TERM_Y [NUM_TERMS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
    localparam logic [1:0] TERM_Z [NUM_TERMS] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
    localparam logic [NUM_TERMS-1:0] TERM_NEG = 6'b100110;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;
        logic       diff;
        logic       mul1;
        logic       mul2;
        logic       acc;
        logic       save4;
        logic       chk;
        logic       wmul;
        logic       wacc;
        logic       div_init;
        logic       div_step;
        logic       fin;
        logic [2:0] sel;
        logic [2:0] term;
        logic [1:0] chunk;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic det_zero;
        logic is_query;
        logic ok;
    } t_status;

endpackage

@@ rtl/tvi_datapath.sv @@
// Datapath: vertex registers, difference rows, shared multiplier,
// determinant and numerator accumulators, restoring divider and result register.
// Depends on tvi_pkg.
module tvi_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tvi_pkg::t_cmd                          i_cmd,
    output tvi_pkg::t_status                       o_status,
    input  logic                                   i_req_type,
    input  logic [tvi_pkg::SLOT_W-1:0]             i_vertex_slot,
    input  logic signed [tvi_pkg::COORD_W-1:0]     i_vert_x,
    input  logic signed [tvi_pkg::COORD_W-1:0]     i_vert_y,
    input  logic signed [tvi_pkg::COORD_W-1:0]     i_vert_z,
    input  logic signed [tvi_pkg::VALUE_W-1:0]     i_vert_value,
    input  logic [tvi_pkg::INDEX_BITS-1:0]         i_voxel_x,
    input  logic [tvi_pkg::INDEX_BITS-1:0]         i_voxel_y,
    input  logic [tvi_pkg::INDEX_BITS-1:0]         i_voxel_z,
    output logic                                   o_inside_res,
    output logic signed [tvi_pkg::VALUE_W-1:0]     o_interp_value,
    output logic                                   o_degenerate
);
    import tvi_pkg::*;

    logic signed [COORD_W-1:0] r_vx  [NUM_VERT];
    logic signed [COORD_W-1:0] r_vy  [NUM_VERT];
    logic signed [COORD_W-1:0] r_vz  [NUM_VERT];
    logic signed [VALUE_W-1:0] r_val [NUM_VERT];

    logic                  r_is_query;
    logic [INDEX_BITS-1:0] r_vox_x, r_vox_y, r_vox_z;

    logic signed [DIFF_W-1:0] r_da [3];
    logic signed [DIFF_W-1:0] r_db [3];
    logic signed [DIFF_W-1:0] r_dc [3];

    logic signed [MP_W-1:0]  r_prod;
    logic signed [DET_W-1:0] r_det;
    logic signed [DET_W-1:0] r_det4;
    logic                    r_det4_zero;
    logic                    r_ok;
    logic signed [NUM_W-1:0] r_num;

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic             r_neg;
    logic             r_ovf;

    logic                    r_inside;
    logic signed [VALUE_W-1:0] r_value;
    logic                    r_degen;

    logic signed [COORD_W-1:0] w_pt [NUM_VERT][3];
    logic signed [COORD_W-1:0] w_vox [3];
    logic signed [DIFF_W-1:0]  w_x, w_y, w_z;
    logic signed [MA_W-1:0]    w_ma;
    logic signed [MB_W-1:0]    w_mb;
    logic signed [MP_W-1:0]    w_mp;
    logic signed [DET_W-1:0]   w_term;
    logic signed [NUM_W-1:0]   w_pext;
    logic signed [NUM_W-1:0]   w_pshift;
    logic [NUM_W-1:0]          w_nabs;
    logic [DET_W-1:0]          w_dabs;
    logic [MAG_W-1:0]          w_mag;
    logic signed [VALUE_W-1:0] w_sat;
    logic                      w_inside;

    // Voxel index scaled to coordinate format
    assign w_vox[0] = signed'({1'b0, r_vox_x, {COORD_FRAC_BITS{1'b0}}});
    assign w_vox[1] = signed'({1'b0, r_vox_y, {COORD_FRAC_BITS{1'b0}}});
    assign w_vox[2] = signed'({1'b0, r_vox_z, {COORD_FRAC_BITS{1'b0}}});

    // Substitute the voxel for the selected vertex
    always_comb begin
        for (int k = 0; k < NUM_VERT; k++) begin
            if (i_cmd.sel == 3'(k)) begin
                w_pt[k][0] = w_vox[0];
                w_pt[k][1] = w_vox[1];
                w_pt[k][2] = w_vox[2];
            end else begin
                w_pt[k][0] = r_vx[k];
                w_pt[k][1] = r_vy[k];
                w_pt[k][2] = r_vz[k];
            end
        end
    end

    // Operands of the current cofactor term
    assign w_x = r_da[i_cmd.term[2:1]];
    assign w_y = r_db[TERM_Y[i_cmd.term]];
    assign w_z = r_dc[TERM_Z[i_cmd.term]];

    // Shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (i_cmd.mul1) begin
            w_ma = {{(MA_W-DIFF_W){w_x[DIFF_W-1]}}, w_x};
            w_mb = {{(MB_W-DIFF_W){w_y[DIFF_W-1]}}, w_y};
        end else if (i_cmd.mul2) begin
            w_ma = r_prod[MA_W-1:0];
            w_mb = {{(MB_W-DIFF_W){w_z[DIFF_W-1]}}, w_z};
        end else if (i_cmd.wmul) begin
            w_ma = {{(MA_W-VALUE_W){r_val[i_cmd.sel[1:0]][VALUE_W-1]}},
                    r_val[i_cmd.sel[1:0]]};
            case (i_cmd.chunk)
                2'd0:    w_mb = {1'b0, r_det[CHUNK_W-1:0]};
                2'd1:    w_mb = {1'b0, r_det[2*CHUNK_W-1:CHUNK_W]};
                default: w_mb = {r_det[DET_W-1], r_det[DET_W-1:2*CHUNK_W]};
            endcase
        end
    end

    assign w_mp   = w_ma * w_mb;
    assign w_term = r_prod[DET_W-1:0];

    // Weighted partial product aligned to its chunk
    assign w_pext = {{(NUM_W-MP_W){r_prod[MP_W-1]}}, r_prod};
    always_comb begin
        case (i_cmd.chunk)
            2'd0:    w_pshift = w_pext;
            2'd1:    w_pshift = w_pext <<< CHUNK_W;
            default: w_pshift = w_pext <<< (2 * CHUNK_W);
        endcase
    end

    // Magnitudes for the divider
    assign w_nabs = r_num[NUM_W-1] ? (~r_num + NUM_W'(1)) : r_num;
    assign w_dabs = r_det4[DET_W-1] ? (~r_det4 + DET_W'(1)) : r_det4;

    // Floor and saturate the quotient
    assign w_mag = {1'b0, r_quo} + MAG_W'(r_neg && (r_rem != '0));
    always_comb begin
        if (r_ovf) begin
            w_sat = r_neg ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end else if (r_neg) begin
            if (w_mag > MAG_W'({1'b1, {(VALUE_W-1){1'b0}}})) begin
                w_sat = {1'b1, {(VALUE_W-1){1'b0}}};
            end else begin
                w_sat = -signed'(w_mag[VALUE_W-1:0]);
            end
        end else begin
            if (w_mag > MAG_W'({(VALUE_W-1){1'b1}})) begin
                w_sat = {1'b0, {(VALUE_W-1){1'b1}}};
            end else begin
                w_sat = signed'(w_mag[VALUE_W-1:0]);
            end
        end
    end

    assign w_inside = r_is_query && r_ok && !r_det4_zero;

    // Vertex store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VERT; k++) begin
                r_vx[k]  <= '0;
                r_vy[k]  <= '0;
                r_vz[k]  <= '0;
                r_val[k] <= '0;
            end
        end else if (i_cmd.accept && i_req_type == REQ_LOAD) begin
            r_vx[i_vertex_slot]  <= i_vert_x;
            r_vy[i_vertex_slot]  <= i_vert_y;
            r_vz[i_vertex_slot]  <= i_vert_z;
            r_val[i_vertex_slot] <= i_vert_value;
        end
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_query <= (i_req_type == REQ_QUERY);
            r_vox_x    <= i_voxel_x;
            r_vox_y    <= i_voxel_y;
            r_vox_z    <= i_voxel_z;
            r_ok       <= 1'b1;
            r_num      <= '0;
        end
        if (i_cmd.diff) begin
            for (int j = 0; j < 3; j++) begin
                r_da[j] <= {w_pt[1][j][COORD_W-1], w_pt[1][j]}
                         - {w_pt[0][j][COORD_W-1], w_pt[0][j]};
                r_db[j] <= {w_pt[2][j][COORD_W-1], w_pt[2][j]}
                         - {w_pt[0][j][COORD_W-1], w_pt[0][j]};
                r_dc[j] <= {w_pt[3][j][COORD_W-1], w_pt[3][j]}
                         - {w_pt[0][j][COORD_W-1], w_pt[0][j]};
            end
        end
        if (i_cmd.mul1 || i_cmd.mul2 || i_cmd.wmul) begin
            r_prod <= w_mp;
        end
        // Accumulate one signed cofactor term
        if (i_cmd.acc) begin
            if (TERM_NEG[i_cmd.term]) begin
                r_det <= ((i_cmd.term == '0) ? '0 : r_det) - w_term;
            end else begin
                r_det <= ((i_cmd.term == '0) ? '0 : r_det) + w_term;
            end
        end
        if (i_cmd.save4) begin
            r_det4      <= r_det;
            r_det4_zero <= (r_det == '0);
        end
        // Drop the voxel on a zero or opposite-sign determinant
        if (i_cmd.chk) begin
            if (r_det == '0 || r_det[DET_W-1] != r_det4[DET_W-1]) begin
                r_ok <= 1'b0;
            end
        end
        if (i_cmd.wacc) begin
            r_num <= r_num + w_pshift;
        end
        // Restoring division, one quotient bit per step
        if (i_cmd.div_init) begin
            r_rem <= w_nabs;
            r_dsh <= NUM_W'(w_dabs) << (QUO_W - 1);
            r_ovf <= (w_nabs >= (NUM_W'(w_dabs) << QUO_W));
            r_neg <= r_num[NUM_W-1] ^ r_det4[DET_W-1];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
        // Capture the whole result so a waiting item stays intact
        if (i_cmd.fin) begin
            r_inside <= w_inside;
            r_value  <= w_inside ? w_sat : '0;
            r_degen  <= r_det4_zero;
        end
    end

    assign o_status.det_zero = (r_det == '0);
    assign o_status.is_query = r_is_query;
    assign o_status.ok       = r_ok;

    assign o_inside_res   = r_inside;
    assign o_interp_value = r_value;
    assign o_degenerate   = r_degen;

endmodule

@@ rtl/tvi_ctrl.sv @@
// Controller: sequences determinant terms, weighting, division and result hand-off.
// Depends on tvi_pkg.
module tvi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tvi_pkg::t_cmd    o_cmd,
    input  tvi_pkg::t_status i_status
);
    import tvi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL1, S_MUL2, S_ACC, S_DET_END,
        S_WMUL, S_WACC, S_DIV_INIT, S_DIV_STEP, S_FIN
    } t_state;

    t_state     r_state;
    logic [2:0] r_sel;
    logic [2:0] r_term;
    logic [1:0] r_chunk;
    logic [5:0] r_step;
    logic       r_out_valid;
    logic       w_fin;

    assign w_fin = (r_state == S_FIN) && !(r_out_valid && i_out_stall);

    // Decode commands from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = r_sel;
        o_cmd.term     = r_term;
        o_cmd.chunk    = r_chunk;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.diff     = (r_state == S_DIFF);
        o_cmd.mul1     = (r_state == S_MUL1);
        o_cmd.mul2     = (r_state == S_MUL2);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.save4    = (r_state == S_DET_END) && (r_sel == SEL_NONE);
        o_cmd.chk      = (r_state == S_DET_END) && (r_sel != SEL_NONE);
        o_cmd.wmul     = (r_state == S_WMUL);
        o_cmd.wacc     = (r_state == S_WACC);
        o_cmd.div_init = (r_state == S_DIV_INIT);
        o_cmd.div_step = (r_state == S_DIV_STEP);
        o_cmd.fin      = w_fin;
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_NONE;
            r_term      <= '0;
            r_chunk     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on a finished item, release it once taken
            r_out_valid <= w_fin || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sel   <= SEL_NONE;
                        r_term  <= '0;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF:  r_state <= S_MUL1;
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= S_ACC;
                S_ACC: begin
                    if (r_term == 3'(NUM_TERMS - 1)) begin
                        r_state <= S_DET_END;
                    end else begin
                        r_term  <= r_term + 3'd1;
                        r_state <= S_MUL1;
                    end
                end
                S_DET_END: begin
                    if (r_sel == SEL_NONE) begin
                        if (!i_status.is_query || i_status.det_zero) begin
                            r_state <= S_FIN;
                        end else begin
                            r_sel   <= '0;
                            r_term  <= '0;
                            r_state <= S_DIFF;
                        end
                    end else begin
                        r_chunk <= '0;
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL:  r_state <= S_WACC;
                S_WACC: begin
                    if (r_chunk != 2'(NUM_CHUNKS - 1)) begin
                        r_chunk <= r_chunk + 2'd1;
                        r_state <= S_WMUL;
                    end else if (r_sel == SEL_LAST) begin
                        r_state <= i_status.ok ? S_DIV_INIT : S_FIN;
                    end else begin
                        r_sel   <= r_sel + 3'd1;
                        r_term  <= '0;
                        r_state <= S_DIFF;
                    end
                end
                S_DIV_INIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    if (r_step == 6'(QUO_W - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                S_FIN: begin
                    if (w_fin) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/tetrahedron_voxel_interpolator.sv @@
// Top level of the tetrahedron voxel interpolator.
// Depends on tvi_pkg, tvi_ctrl and tvi_datapath.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  input   | i_in_valid / o_in_stall   | req_type, vertex_slot, vert_*, voxel_*
//  output  | o_out_valid / i_out_stall | inside_res, interp_value, degenerate
//
// One item at a time. A load, or a query on a degenerate tetrahedron, ends after its
// determinant; other queries add four substituted determinants and weighting, and
// inside ones the division. The single shared 42x22 multiplier does two multiplies
// per cofactor term (30 terms, 12 weighting products); the divider takes 33 steps.
// Reset is synchronous, active low, and clears the vertices to zero.
// A new item is accepted while a finished result still waits on o_out_valid.
module tetrahedron_voxel_interpolator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_req_type,
    input  logic [tvi_pkg::SLOT_W-1:0]             i_vertex_slot,
    input  logic signed [tvi_pkg::COORD_W-1:0]     i_vert_x,
    input  logic signed [tvi_pkg::COORD_W-1:0]     i_vert_y,
    input  logic signed [tvi_pkg::COORD_W-1:0]     i_vert_z,
    input  logic signed [tvi_pkg::VALUE_W-1:0]     i_vert_value,
    input  logic [tvi_pkg::INDEX_BITS-1:0]         i_voxel_x,
    input  logic [tvi_pkg::INDEX_BITS-1:0]         i_voxel_y,
    input  logic [tvi_pkg::INDEX_BITS-1:0]         i_voxel_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_inside_res,
    output logic signed [tvi_pkg::VALUE_W-1:0]     o_interp_value,
    output logic                                   o_degenerate
);
    import tvi_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    tvi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Arithmetic and storage
    tvi_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_req_type     (i_req_type),
        .i_vertex_slot  (i_vertex_slot),
        .i_vert_x       (i_vert_x),
        .i_vert_y       (i_vert_y),
        .i_vert_z       (i_vert_z),
        .i_vert_value   (i_vert_value),
        .i_voxel_x      (i_voxel_x),
        .i_voxel_y      (i_voxel_y),
        .i_voxel_z      (i_voxel_z),
        .o_inside_res   (o_inside_res),
        .o_interp_value (o_interp_value),
        .o_degenerate   (o_degenerate)
    );

endmodule

@@ rtl/tvi_checker.sv @@
// Port-level checks for the tetrahedron voxel interpolator, bound to the top level.
// Depends on tvi_pkg.
module tvi_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_inside_res,
    input logic signed [tvi_pkg::VALUE_W-1:0] o_interp_value,
    input logic                               o_degenerate
);
    import tvi_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_inside_res)
            && $stable(o_interp_value) && $stable(o_degenerate))
        else $error("stalled result changed");

    // Busy right after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while busy");

    // Nothing lies inside a degenerate tetrahedron
    a_inside_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_res |-> !o_degenerate)
        else $error("inside reported on degenerate tetrahedron");

    // Outside results carry zero
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_res |-> o_interp_value == '0)
        else $error("nonzero value on outside result");

endmodule

bind tetrahedron_voxel_interpolator tvi_checker u_tvi_checker (.*);
